@@ hw/rtl/tecm_pkg.sv @@
package tecm_pkg;

	// fixed field widths
	localparam int unsigned TYPE_W     = 16;
	localparam int unsigned CODE_W     = 16;
	localparam int unsigned CAL_W      = 32;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned ORIENT_W   = 3;

	// event types and codes
	localparam logic [TYPE_W-1:0] EV_SYN = 16'h0000;
	localparam logic [TYPE_W-1:0] EV_KEY = 16'h0001;
	localparam logic [TYPE_W-1:0] EV_ABS = 16'h0003;

	localparam logic [CODE_W-1:0] SYN_FRAME = 16'h0000;
	localparam logic [CODE_W-1:0] ABS_X     = 16'h0000;
	localparam logic [CODE_W-1:0] ABS_Y     = 16'h0001;
	localparam logic [CODE_W-1:0] ABS_MT_X  = 16'h0035;
	localparam logic [CODE_W-1:0] ABS_MT_Y  = 16'h0036;
	localparam logic [CODE_W-1:0] ABS_MT_ID = 16'h0039;
	localparam logic [CODE_W-1:0] KEY_TOUCH = 16'h014A;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_X     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MIN_Y     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_MAX_Y     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION   = 3'd6;

	// orientation bits
	localparam int unsigned ORIENT_SWAP  = 0;
	localparam int unsigned ORIENT_INV_X = 1;
	localparam int unsigned ORIENT_INV_Y = 2;

	// report sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_MUL,
		ST_DIV,
		ST_WAIT
	} state_t;

endpackage

@@ hw/rtl/touch_event_coordinate_mapper_unit.sv @@
// Touch event coordinate mapper.
// Input channel (in_valid/in_stall): one input event word per handshake
// (event_type, event_code, event_value). Axis and tracking-id events only
// update the held position and touch state; a touch-button or sync-report
// event produces one output word (pos_x, pos_y, pressed) on the output
// channel (out_valid/out_stall). Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data); it is to be used only while the block is
// idle, and the block itself does not enforce this. Non-report events keep
// the sequencer idle, so such words go back to back. A report with mapping
// disabled passes the raw held values through the holding stage. A mapped
// report runs each axis through prep, range check, one 32xSCREEN_BITS
// multiply and a radix-2 divider that retires one quotient bit per cycle.
// An axis whose value lands outside the range, a one-pixel axis, or an axis
// without a calibrated range skips the multiply and divide.
// Input is stalled while a report is in flight; it is accepted again as
// soon as the report sits in the output register, even if the receiver
// stalls. A report waits in a holding stage while the output register is
// full and stalled. Reset clears calibration, held position and touch state.
module touch_event_coordinate_mapper_unit #(
	parameter int unsigned VALUE_BITS  = 32,
	parameter int unsigned SCREEN_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// config write port
	input  logic                                 cfg_we,
	input  logic [tecm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tecm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// event input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [tecm_pkg::TYPE_W-1:0]          event_type,
	input  logic [tecm_pkg::CODE_W-1:0]          event_code,
	input  logic signed [VALUE_BITS-1:0]         event_value,
	// report output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [tecm_pkg::POS_W-1:0]    pos_x,
	output logic signed [tecm_pkg::POS_W-1:0]    pos_y,
	output logic                                 pressed
);

	localparam int unsigned SB     = SCREEN_BITS;
	localparam int unsigned CW     = tecm_pkg::CAL_W;
	localparam int unsigned PW     = tecm_pkg::POS_W;
	localparam int unsigned WW     = CW + 2;        // wide signed work value
	localparam int unsigned PROD_W = CW + SB;
	localparam int unsigned CNT_W  = $clog2(SB);

	// configuration registers
	logic signed [CW-1:0]                  cal_min_x_q, cal_max_x_q;
	logic signed [CW-1:0]                  cal_min_y_q, cal_max_y_q;
	logic [SB-1:0]                         screen_width_q, screen_height_q;
	logic [tecm_pkg::ORIENT_W-1:0]         orientation_q;

	// held touch state
	logic signed [VALUE_BITS-1:0]          held_x_q, held_y_q;
	logic                                  held_down_q;

	// sequencer and datapath
	tecm_pkg::state_t                      state_q, state_d;
	logic                                  axis_q;
	logic                                  ranged_q;
	logic signed [WW-1:0]                  val_q;
	logic [CW-1:0]                         den_q;
	logic [CW-1:0]                         rem_q;
	logic [SB-1:0]                         quo_q;
	logic [CNT_W-1:0]                      cnt_q;
	logic [PW-1:0]                         res_x_q, res_y_q;

	// output register
	logic                                  out_valid_q;
	logic signed [PW-1:0]                  pos_x_q, pos_y_q;
	logic                                  pressed_q;

	// control outputs
	logic in_acc;
	logic axis_done;
	logic load_out;

	// ---------------- event decode ----------------
	logic is_abs, upd_x, upd_y, upd_track, is_touch, is_sync, is_report;

	assign in_acc    = in_valid && !in_stall;
	assign is_abs    = (event_type == tecm_pkg::EV_ABS);
	assign upd_x     = is_abs && (event_code == tecm_pkg::ABS_X ||
		event_code == tecm_pkg::ABS_MT_X);
	assign upd_y     = is_abs && (event_code == tecm_pkg::ABS_Y ||
		event_code == tecm_pkg::ABS_MT_Y);
	assign upd_track = is_abs && (event_code == tecm_pkg::ABS_MT_ID);
	assign is_touch  = (event_type == tecm_pkg::EV_KEY) && (event_code == tecm_pkg::KEY_TOUCH);
	assign is_sync   = (event_type == tecm_pkg::EV_SYN) && (event_code == tecm_pkg::SYN_FRAME);
	assign is_report = is_touch || is_sync;

	logic map_en;
	assign map_en = (screen_width_q != '0) && (screen_height_q != '0);

	// ---------------- per-axis operand select ----------------
	logic                 from_y, inv_sel;
	logic signed [CW-1:0] v_sel, lo_sel, hi_sel, hx_w, hy_w;
	logic [SB-1:0]        size_sel, sm1;

	assign hx_w     = CW'(held_x_q);
	assign hy_w     = CW'(held_y_q);
	assign from_y   = axis_q ^ orientation_q[tecm_pkg::ORIENT_SWAP];
	assign v_sel    = from_y ? hy_w : hx_w;
	assign lo_sel   = from_y ? cal_min_y_q : cal_min_x_q;
	assign hi_sel   = from_y ? cal_max_y_q : cal_max_x_q;
	assign inv_sel  = axis_q ? orientation_q[tecm_pkg::ORIENT_INV_Y]
		: orientation_q[tecm_pkg::ORIENT_INV_X];
	assign size_sel = axis_q ? screen_height_q : screen_width_q;
	assign sm1      = size_sel - SB'(1);

	// prep: offset into the range (or the raw value, mirrored when inverted, when unranged)
	logic signed [WW-1:0] v_w, lo_w, hi_w, span_w, prep_val;
	logic                 prep_ranged;

	assign v_w         = WW'(v_sel);
	assign lo_w        = WW'(lo_sel);
	assign hi_w        = WW'(hi_sel);
	assign span_w      = hi_w - lo_w;
	assign prep_ranged = hi_sel > lo_sel;

	always_comb begin
		if (prep_ranged) begin
			prep_val = inv_sel ? (hi_w - v_w) : (v_w - lo_w);
		end else begin
			prep_val = inv_sel ? (lo_w + hi_w - v_w) : v_w;
		end
	end

	// check: clamp cases decided without dividing
	logic          val_neg, val_ge_size, d_ge_den, go_mul;
	logic [SB-1:0] chk_res;

	assign val_neg     = val_q[WW-1];
	assign val_ge_size = val_q[WW-2:0] >= (WW-1)'(size_sel);
	assign d_ge_den    = val_q[WW-2:0] >= (WW-1)'(den_q);
	assign go_mul      = ranged_q && !val_neg && (sm1 != '0) && !d_ge_den;

	always_comb begin
		if (val_neg) begin
			chk_res = '0;
		end else if (ranged_q || val_ge_size) begin
			chk_res = sm1;
		end else begin
			chk_res = val_q[SB-1:0];
		end
	end

	// multiply and one quotient bit per cycle
	logic [PROD_W-1:0] prod;
	logic [CW:0]       div_t, div_sub;
	logic              div_ge, cnt_last;
	logic [SB-1:0]     div_res;

	assign prod     = PROD_W'(val_q[CW-1:0]) * PROD_W'(sm1);
	assign div_t    = {rem_q, quo_q[SB-1]};
	assign div_ge   = div_t >= {1'b0, den_q};
	assign div_sub  = div_t - {1'b0, den_q};
	assign cnt_last = (cnt_q == CNT_W'(SB - 1));
	assign div_res  = {quo_q[SB-2:0], div_ge};

	logic [SB-1:0] axis_res;
	assign axis_res = (state_q == tecm_pkg::ST_DIV) ? div_res : chk_res;

	// ---------------- sequencer next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tecm_pkg::ST_IDLE: begin
				if (in_acc && is_report) begin
					state_d = map_en ? tecm_pkg::ST_PREP : tecm_pkg::ST_WAIT;
				end
			end
			tecm_pkg::ST_PREP: state_d = tecm_pkg::ST_CHECK;
			tecm_pkg::ST_CHECK: begin
				if (go_mul) begin
					state_d = tecm_pkg::ST_MUL;
				end else begin
					state_d = axis_q ? tecm_pkg::ST_WAIT : tecm_pkg::ST_PREP;
				end
			end
			tecm_pkg::ST_MUL: state_d = tecm_pkg::ST_DIV;
			tecm_pkg::ST_DIV: begin
				if (cnt_last) begin
					state_d = axis_q ? tecm_pkg::ST_WAIT : tecm_pkg::ST_PREP;
				end
			end
			tecm_pkg::ST_WAIT: begin
				if (!out_valid_q || !out_stall) begin
					state_d = tecm_pkg::ST_IDLE;
				end
			end
			default: state_d = tecm_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer outputs ----------------
	always_comb begin
		in_stall  = (state_q != tecm_pkg::ST_IDLE);
		axis_done = ((state_q == tecm_pkg::ST_CHECK) && !go_mul) ||
			((state_q == tecm_pkg::ST_DIV) && cnt_last);
		load_out  = (state_q == tecm_pkg::ST_WAIT) && (!out_valid_q || !out_stall);
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tecm_pkg::ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (axis_done) begin
				axis_q <= ~axis_q;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_x_q     <= '0;
			cal_max_x_q     <= '0;
			cal_min_y_q     <= '0;
			cal_max_y_q     <= '0;
			screen_width_q  <= '0;
			screen_height_q <= '0;
			orientation_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tecm_pkg::REG_CAL_MIN_X:     cal_min_x_q     <= cfg_data;
				tecm_pkg::REG_CAL_MAX_X:     cal_max_x_q     <= cfg_data;
				tecm_pkg::REG_CAL_MIN_Y:     cal_min_y_q     <= cfg_data;
				tecm_pkg::REG_CAL_MAX_Y:     cal_max_y_q     <= cfg_data;
				tecm_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[SB-1:0];
				tecm_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data[SB-1:0];
				tecm_pkg::REG_ORIENTATION:
					orientation_q <= cfg_data[tecm_pkg::ORIENT_W-1:0];
				default: ;
			endcase
		end
	end

	// held position and touch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_down_q <= 1'b0;
		end else if (in_acc) begin
			if (upd_x) begin
				held_x_q <= event_value;
			end else if (upd_y) begin
				held_y_q <= event_value;
			end else if (upd_track) begin
				held_down_q <= !event_value[VALUE_BITS-1];
			end else if (is_touch) begin
				held_down_q <= (event_value != '0);
			end
		end
	end

	// ---------------- mapping datapath ----------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			tecm_pkg::ST_IDLE: begin
				// unmapped report: raw held values pass through
				if (in_acc && is_report && !map_en) begin
					res_x_q <= hx_w;
					res_y_q <= hy_w;
				end
			end
			tecm_pkg::ST_PREP: begin
				val_q    <= prep_val;
				ranged_q <= prep_ranged;
				den_q    <= span_w[CW-1:0];
			end
			tecm_pkg::ST_MUL: begin
				rem_q <= prod[PROD_W-1:SB];
				quo_q <= prod[SB-1:0];
				cnt_q <= '0;
			end
			tecm_pkg::ST_DIV: begin
				rem_q <= div_ge ? div_sub[CW-1:0] : div_t[CW-1:0];
				quo_q <= div_res;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: ;
		endcase
		// store finished axis
		if (axis_done) begin
			if (axis_q) begin
				res_y_q <= PW'(axis_res);
			end else begin
				res_x_q <= PW'(axis_res);
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			pos_x_q   <= res_x_q;
			pos_y_q   <= res_y_q;
			pressed_q <= held_down_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign pressed   = pressed_q;

	// ---------------- assertions ----------------
	// a report in the holding stage moves out once the output register frees
	a_report_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tecm_pkg::ST_WAIT && (!out_valid_q || !out_stall)) |=> out_valid_q)
		else $error("report not loaded into output register");

	// partial remainder stays below the divisor
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tecm_pkg::ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder out of range");

	// held state is frozen while a report is in flight
	a_held_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != tecm_pkg::ST_IDLE) |=>
		($stable(held_x_q) && $stable(held_y_q) && $stable(held_down_q)))
		else $error("held state changed during report");

	// each multiply starts a fresh division count
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tecm_pkg::ST_MUL) |=> (state_q == tecm_pkg::ST_DIV && cnt_q == '0))
		else $error("divider did not start cleanly");

endmodule
